FILE: design/rrts_pkg.sv
package rrts_pkg;

  localparam int MaxThreadsDefault   = 16;
  localparam int ContextBytesDefault = 120;

  typedef enum logic [1:0] {
    CMD_SWITCH = 2'd0,
    CMD_CREATE = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_JOIN   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BUSY      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_NO_SLOT   = 3'd3,
    ST_EMPTY     = 3'd4
  } status_code_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FIND,
    S_FIND_DONE,
    S_SW_LINK,
    S_SW_UNLINK,
    S_SW_SKIP,
    S_SW_OUT,
    S_DONE
  } fsm_state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic capture;     // latch input item
    logic find_start;  // load ring walk from head
    logic find_step;   // advance ring walk
    logic find_pend;   // compare pending slot after ring miss
    logic do_create;
    logic do_join;
    logic do_finish;
    logic sw_save;     // save context, choose first candidate
    logic sw_link;
    logic sw_unlink;
    logic skip_start;
    logic skip_step;
    logic sw_emit;
    logic sw_empty;
    logic emit_status;
    status_code_t code;
  } dp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    cmd_t cmd;
    logic running_ok;
    logic pend_new_ok;
    logic pend_done_ok;
    logic free_ok;
    logic find_busy;   // walk has more steps
    logic find_hit;
    logic ring_locked;
    logic cand_ok;
    logic skip_busy;
  } dp_stat_t;

endpackage

FILE: design/rrts_ctrl.sv
module rrts_ctrl
  import rrts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       out_full,
  input  dp_stat_t   st,
  output logic       in_stall,
  output dp_cmd_t    cmd
);

  fsm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid && !out_full) state_next = S_DECODE;
      S_DECODE: begin
        unique case (st.cmd)
          CMD_SWITCH: state_next = S_SW_LINK;
          CMD_CREATE: state_next = S_DONE;
          CMD_FINISH: state_next = (st.running_ok && !st.pend_done_ok) ? S_FIND : S_DONE;
          CMD_JOIN:   state_next = st.running_ok ? S_FIND : S_DONE;
          default:    state_next = S_DONE;
        endcase
      end
      S_FIND:      if (st.find_hit || !st.find_busy) state_next = S_FIND_DONE;
      S_FIND_DONE: state_next = S_DONE;
      S_SW_LINK:   state_next = S_SW_UNLINK;
      S_SW_UNLINK: state_next = S_SW_SKIP;
      S_SW_SKIP:   if (!st.cand_ok || !st.skip_busy) state_next = S_SW_OUT;
      S_SW_OUT:    state_next = S_IDLE;
      S_DONE:      state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.code = ST_OK;
    in_stall = rst || !(state == S_IDLE && !out_full);
    unique case (state)
      S_IDLE: cmd.capture = in_valid && !out_full;
      S_DECODE: begin
        unique case (st.cmd)
          CMD_SWITCH: cmd.sw_save = 1'b1;
          CMD_CREATE: begin
            if (st.pend_new_ok) cmd.code = ST_BUSY;
            else if (!st.free_ok) cmd.code = ST_NO_SLOT;
            else cmd.do_create = 1'b1;
          end
          CMD_FINISH: begin
            if (!st.running_ok) cmd.code = ST_EMPTY;
            else if (st.pend_done_ok) cmd.code = ST_BUSY;
            else cmd.find_start = 1'b1;
          end
          CMD_JOIN: begin
            if (!st.running_ok) cmd.code = ST_EMPTY;
            else cmd.find_start = 1'b1;
          end
          default: ;
        endcase
      end
      S_FIND: if (!st.find_hit && st.find_busy) cmd.find_step = 1'b1;
      S_FIND_DONE: begin
        if (st.cmd == CMD_FINISH) begin
          cmd.do_finish = 1'b1;
        end else begin
          cmd.find_pend = 1'b1;
          cmd.do_join = 1'b1;
        end
      end
      S_SW_LINK:   cmd.sw_link = !st.ring_locked;
      S_SW_UNLINK: begin
        cmd.sw_unlink = !st.ring_locked;
        cmd.skip_start = 1'b1;
      end
      S_SW_SKIP:   if (st.cand_ok && st.skip_busy) cmd.skip_step = 1'b1;
      S_SW_OUT: begin
        if (st.cand_ok) cmd.sw_emit = 1'b1;
        else cmd.sw_empty = 1'b1;
      end
      S_DONE: cmd.emit_status = 1'b1;
      default: ;
    endcase
  end

endmodule

FILE: design/rrts_dp.sv
module rrts_dp
  import rrts_pkg::*;
#(
  parameter int MAX_THREADS   = MaxThreadsDefault,
  parameter int CONTEXT_BYTES = ContextBytesDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  dp_cmd_t      cmd,
  output dp_stat_t     st,
  input  logic [1:0]   cmd_in,
  input  logic         ring_locked_in,
  input  logic [31:0]  ctx_status_in,
  input  logic [31:0]  ctx_pc_in,
  input  logic [31:0]  ctx_stack_in,
  input  logic [15:0]  target_id_in,
  input  logic [31:0]  rtn_value_in,
  input  logic         out_stall,
  output logic         out_valid,
  output logic [2:0]   out_status,
  output logic [15:0]  out_run_id,
  output logic [31:0]  out_next_status,
  output logic [31:0]  out_next_pc,
  output logic [31:0]  out_next_stack
);

  localparam int SW = $clog2(MAX_THREADS);
  localparam int PW = SW + 1;
  localparam logic [PW-1:0] NONE = PW'(MAX_THREADS);

  logic [MAX_THREADS-1:0] slot_used, slot_waiting;
  logic [15:0] slot_tid    [MAX_THREADS];
  logic [31:0] slot_status_word [MAX_THREADS];
  logic [31:0] slot_pc     [MAX_THREADS];
  logic [31:0] slot_stack  [MAX_THREADS];
  logic [15:0] slot_joiner [MAX_THREADS];
  logic [31:0] slot_result [MAX_THREADS];
  logic [SW-1:0] slot_next [MAX_THREADS];
  logic [SW-1:0] slot_prev [MAX_THREADS];

  logic [PW-1:0] running_slot, pending_new, pending_done, ring_head, cand, walk, skip;
  logic [PW-1:0] ring_count, walk_k, skip_k;
  logic [15:0] id_counter;

  logic [1:0]  r_cmd;
  logic        r_locked;
  logic [31:0] r_status, r_pc, r_stack, r_rtn;
  logic [15:0] r_target, find_id;
  logic        find_hit;

  // Status codes are latched in decode and after the search.
  status_code_t out_code_new, out_code_other;

  logic [PW-1:0] free_slot;
  always_comb begin
    free_slot = NONE;
    for (int i = MAX_THREADS - 1; i >= 0; i--) begin
      if (!slot_used[i]) free_slot = PW'(i);
    end
  end

  function automatic logic ok(input logic [PW-1:0] s);
    return s < NONE;
  endfunction

  function automatic logic [SW-1:0] ix(input logic [PW-1:0] s);
    return s[SW-1:0];
  endfunction

  logic walk_busy, walk_match;
  assign walk_busy  = (walk_k < ring_count) && ok(walk);
  assign walk_match = walk_busy && slot_tid[ix(walk)] == find_id;
  logic skip_busy;
  assign skip_busy = slot_waiting[ix(skip)] && slot_next[ix(skip)] != ix(cand) &&
                     (skip_k < NONE);

  assign st.cmd          = cmd_t'(r_cmd);
  assign st.running_ok   = ok(running_slot);
  assign st.pend_new_ok  = ok(pending_new);
  assign st.pend_done_ok = ok(pending_done);
  assign st.free_ok      = ok(free_slot);
  assign st.find_busy    = walk_busy && !walk_match;
  assign st.find_hit     = find_hit || walk_match;
  assign st.ring_locked  = r_locked;
  assign st.cand_ok      = ok(cand);
  assign st.skip_busy    = skip_busy;

  // Unlink helper values.
  logic [SW-1:0] dn, dp;
  assign dn = slot_next[ix(pending_done)];
  assign dp = slot_prev[ix(pending_done)];

  // Candidate as it stands once the removal of this cycle has landed.
  logic [PW-1:0] cand_unl;
  always_comb begin
    cand_unl = cand;
    if (cmd.sw_unlink && ok(pending_done) && ring_count != 0) begin
      if (ring_count == PW'(1)) cand_unl = NONE;
      else if (pending_done == cand) cand_unl = {1'b0, dn};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used    <= '0;
      slot_waiting <= '0;
      running_slot <= NONE;
      pending_new  <= NONE;
      pending_done <= NONE;
      ring_head    <= NONE;
      ring_count   <= '0;
      id_counter   <= 16'd1;
      out_valid    <= 1'b0;
      find_hit     <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cmd.capture) begin
        r_cmd <= cmd_in; r_locked <= ring_locked_in;
        r_status <= ctx_status_in; r_pc <= ctx_pc_in; r_stack <= ctx_stack_in;
        r_target <= target_id_in; r_rtn <= rtn_value_in;
      end
      if (cmd.find_start) begin
        walk <= ring_head; walk_k <= '0; find_hit <= 1'b0;
        find_id <= (cmd_t'(r_cmd) == CMD_FINISH) ? slot_joiner[ix(running_slot)] : r_target;
      end else if (walk_match && !find_hit) begin
        find_hit <= 1'b1;
      end
      if (cmd.find_step) begin
        walk <= {1'b0, slot_next[ix(walk)]};
        walk_k <= walk_k + 1'b1;
      end
      if (cmd.do_create) begin
        slot_used[ix(free_slot)] <= 1'b1;
        slot_tid[ix(free_slot)] <= id_counter;
        slot_status_word[ix(free_slot)] <= r_status;
        slot_pc[ix(free_slot)] <= r_pc;
        slot_stack[ix(free_slot)] <= r_stack - 32'(CONTEXT_BYTES);
        slot_joiner[ix(free_slot)] <= '0;
        slot_waiting[ix(free_slot)] <= 1'b0;
        slot_result[ix(free_slot)] <= '0;
        pending_new <= free_slot;
        id_counter <= (id_counter == 16'hFFFF) ? 16'd1 : id_counter + 16'd1;
      end
      if (cmd.do_join) begin
        if (st.find_hit) begin
          slot_joiner[ix(walk)] <= slot_tid[ix(running_slot)];
          slot_waiting[ix(running_slot)] <= 1'b1;
        end else if (ok(pending_new) && slot_tid[ix(pending_new)] == r_target) begin
          slot_joiner[ix(pending_new)] <= slot_tid[ix(running_slot)];
          slot_waiting[ix(running_slot)] <= 1'b1;
        end
      end
      if (cmd.do_finish) begin
        slot_result[ix(running_slot)] <= r_rtn;
        if (st.find_hit) slot_waiting[ix(walk)] <= 1'b0;
        pending_done <= running_slot;
      end
      if (cmd.sw_save) begin
        if (ok(running_slot)) begin
          slot_status_word[ix(running_slot)] <= r_status;
          slot_pc[ix(running_slot)] <= r_pc;
          slot_stack[ix(running_slot)] <= r_stack;
          cand <= {1'b0, slot_next[ix(running_slot)]};
        end else begin
          cand <= (ring_count != 0) ? ring_head : NONE;
        end
      end
      if (cmd.sw_link && ok(pending_new)) begin
        if (!ok(cand)) begin
          slot_next[ix(pending_new)] <= ix(pending_new);
          slot_prev[ix(pending_new)] <= ix(pending_new);
          ring_head <= pending_new;
          cand <= pending_new;
        end else begin
          slot_next[ix(pending_new)] <= slot_next[ix(cand)];
          slot_prev[ix(pending_new)] <= ix(cand);
          slot_prev[slot_next[ix(cand)]] <= ix(pending_new);
          slot_next[ix(cand)] <= ix(pending_new);
        end
        ring_count <= ring_count + 1'b1;
        pending_new <= NONE;
      end
      if (cmd.sw_unlink && ok(pending_done) && ring_count != 0) begin
        ring_count <= ring_count - 1'b1;
        pending_done <= NONE;
        slot_used[ix(pending_done)] <= 1'b0;
        slot_waiting[ix(pending_done)] <= 1'b0;
        if (ring_count == PW'(1)) begin
          cand <= NONE; ring_head <= NONE;
        end else begin
          slot_next[dp] <= dn;
          slot_prev[dn] <= dp;
          if (pending_done == cand) begin
            cand <= {1'b0, dn};
            if (pending_done == ring_head) ring_head <= {1'b0, dn};
          end else if (pending_done == ring_head) begin
            ring_head <= cand;
          end
        end
      end
      if (cmd.skip_start) begin
        skip <= cand_unl; skip_k <= '0;
      end
      if (cmd.skip_step) begin
        skip <= {1'b0, slot_next[ix(skip)]};
        skip_k <= skip_k + 1'b1;
      end
      if (cmd.sw_emit) begin
        running_slot <= skip;
        out_valid <= 1'b1;
        out_status <= ST_OK;
        out_run_id <= slot_tid[ix(skip)];
        out_next_status <= slot_status_word[ix(skip)];
        out_next_pc <= slot_pc[ix(skip)];
        out_next_stack <= slot_stack[ix(skip)];
      end
      if (cmd.sw_empty) begin
        running_slot <= NONE;
        out_valid <= 1'b1;
        out_status <= ST_EMPTY;
        out_run_id <= '0;
        out_next_status <= '0; out_next_pc <= '0; out_next_stack <= '0;
      end
      if (cmd.emit_status) begin
        out_valid <= 1'b1;
        out_next_status <= '0; out_next_pc <= '0; out_next_stack <= '0;
        if (cmd_t'(r_cmd) == CMD_CREATE && out_code_new == ST_OK) begin
          out_status <= ST_OK;
          out_run_id <= id_counter == 16'd1 ? 16'hFFFF : id_counter - 16'd1;
        end else if (cmd_t'(r_cmd) == CMD_CREATE) begin
          out_status <= out_code_new;
          out_run_id <= '0;
        end else begin
          out_status <= out_code_other;
          out_run_id <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.code != ST_OK || cmd.do_create) out_code_new <= cmd.code;
    if (cmd.capture) out_code_other <= ST_OK;
    else if (cmd.code != ST_OK) out_code_other <= cmd.code;
    else if (cmd.do_join && !st.find_hit &&
             !(ok(pending_new) && slot_tid[ix(pending_new)] == r_target))
      out_code_other <= ST_NOT_FOUND;
    if (cmd.capture) out_code_new <= ST_OK;
  end

endmodule

FILE: design/round_robin_thread_scheduler.sv
// Channel  | Handshake          | Payload
// ---------+--------------------+------------------------------------------------
// input    | in_valid/in_stall  | cmd ring_locked ctx_status ctx_pc ctx_stack
//          |                    | target_id rtn_value
// output   | out_valid/out_stall| status run_id next_status next_pc next_stack
//
// One item at a time. Create, and a join or finish refused at decode, go from
// decode straight to the result; other joins and finishes first walk the ring
// for the id (up to MAX_THREADS slots), and switch first skips waiting threads
// (up to MAX_THREADS). Reset (rst, synchronous) empties the ring, frees all
// slots and sets the id counter to 1. A held result blocks the next item until
// taken; the next item goes in the cycle after.
module round_robin_thread_scheduler
  import rrts_pkg::*;
#(
  parameter int MAX_THREADS   = MaxThreadsDefault,
  parameter int CONTEXT_BYTES = ContextBytesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic        ring_locked,
  input  logic [31:0] ctx_status,
  input  logic [31:0] ctx_pc,
  input  logic [31:0] ctx_stack,
  input  logic [15:0] target_id,
  input  logic [31:0] rtn_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [15:0] run_id,
  output logic [31:0] next_status,
  output logic [31:0] next_pc,
  output logic [31:0] next_stack
);

  dp_cmd_t  dcmd;
  dp_stat_t dstat;

  // Hold new items while a result still waits.
  rrts_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .out_full(out_valid),
    .st(dstat), .in_stall(in_stall), .cmd(dcmd)
  );

  rrts_dp #(.MAX_THREADS(MAX_THREADS), .CONTEXT_BYTES(CONTEXT_BYTES)) u_dp (
    .clk(clk), .rst(rst), .cmd(dcmd), .st(dstat),
    .cmd_in(cmd), .ring_locked_in(ring_locked), .ctx_status_in(ctx_status),
    .ctx_pc_in(ctx_pc), .ctx_stack_in(ctx_stack), .target_id_in(target_id),
    .rtn_value_in(rtn_value), .out_stall(out_stall), .out_valid(out_valid),
    .out_status(status), .out_run_id(run_id), .out_next_status(next_status),
    .out_next_pc(next_pc), .out_next_stack(next_stack)
  );

`ifndef SYNTH
  // An item is never taken while a result is still held.
  a_no_accept_full: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("item accepted over held result");
  // Every accepted item leads to a result before the next is taken.
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall) else $error("back to back accept");
  // Status codes stay in range.
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= 3'd4) else $error("bad status");
`endif

endmodule
